FILE: sv/gbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the go-back-N sender window
// Holds default parameter values, configuration layout, function and
// timer codes, and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Default sizes handed to the top level parameters.
    localparam int WINDOW_MAX_DEF   = 8;
    localparam int SEQ_BITS_DEF     = 4;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Configuration register layout.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CFG_LIMIT_BITS = 4;
    localparam int CFG_MOD_BITS   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEQ_MODULUS  = 2'd1;

    localparam logic [CFG_LIMIT_BITS-1:0] WINDOW_LIMIT_RESET = 4'd4;
    localparam logic [CFG_MOD_BITS-1:0]   SEQ_MODULUS_RESET  = 5'd8;

    // Duplicate acknowledgements that trigger a fast resend.
    localparam logic [1:0] DUP_RESEND = 2'd3;

    // Input function codes.
    typedef enum logic [1:0] {
        FUNC_SEND    = 2'd0,
        FUNC_ACK     = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    // Timer action codes.
    typedef enum logic [1:0] {
        TA_NONE    = 2'd0,
        TA_START   = 2'd1,
        TA_STOP    = 2'd2,
        TA_RESTART = 2'd3
    } timer_act_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_mem;
        logic advance;
        logic cfg_write;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
        logic walk_more;
    } dp_status_t;

endpackage : gbn_pkg
`default_nettype wire

FILE: sv/go_back_n_sender_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_window: go-back-N sender window with fast resend
// Tracks outstanding packets, stores their payload words and produces the
// packet and timer beats for send requests, ACKs and timer expiries.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes one event beat, a send
// request, an ACK arrival or a timer expiry, selected by func. The output
// channel (out_valid/out_ready) delivers the result beats of that event; last
// marks the final one. The configuration channel (cfg_valid/cfg_ready) writes
// window_limit (index 0) or seq_modulus (index 1) and flushes the window; it
// is taken only between events and goes ahead of an event offered with it.
// For a send, an ACK without resend or an ignored event, the beat is offered
// in the cycle after acceptance, and the next event can be taken in the
// cycle after that beat is taken. A beat carrying a stored word (fast resend
// or timeout) first waits in the read state for the registered store read; a
// timeout walk of at most WINDOW_MAX packets reads again for each further one.
// Reset clears the window and loads limit 4 and modulus 8; the payload store
// is not cleared. When the receiver stalls, the result beat holds and no new
// event or configuration write is taken.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
    parameter int WINDOW_MAX   = gbn_pkg::WINDOW_MAX_DEF,
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          func,
    input  wire logic [PAYLOAD_BITS-1:0]             payload,
    input  wire logic [SEQ_BITS-1:0]                 ack_number,
    input  wire logic                                ack_checksum_ok,
    input  wire logic [SEQ_BITS-1:0]                 timeout_seq,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     accepted,
    output logic                                     packet_valid,
    output logic [SEQ_BITS-1:0]                      packet_seq,
    output logic [PAYLOAD_BITS-1:0]                  packet_payload,
    output logic [1:0]                               timer_action,
    output logic [SEQ_BITS-1:0]                      timer_seq,
    output logic                                     window_full,
    output logic                                     last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gbn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import gbn_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencing controller.
    gbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Window state, payload store and result register.
    gbn_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .payload         (payload),
        .ack_number      (ack_number),
        .ack_checksum_ok (ack_checksum_ok),
        .timeout_seq     (timeout_seq),
        .accepted        (accepted),
        .packet_valid    (packet_valid),
        .packet_seq      (packet_seq),
        .packet_payload  (packet_payload),
        .timer_action    (timer_action),
        .timer_seq       (timer_seq),
        .window_full     (window_full),
        .last            (last)
    );

endmodule : go_back_n_sender_window
`default_nettype wire

FILE: sv/gbn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ctrl: sequencing controller of the go-back-N sender window
// Takes one input beat at a time, waits for a window store read where the
// result carries a stored word, and presents each result beat until taken.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire gbn_pkg::dp_status_t status,
    output gbn_pkg::ctrl_cmd_t      cmd
);
    import gbn_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state. A configuration write goes ahead of an event offered with it.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    state_next = status.need_read ? ST_READ : ST_EMIT;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.walk_more ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshakes and datapath commands.
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cfg_ready     = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load_mem  = 1'b0;
        cmd.advance   = 1'b0;
        cmd.cfg_write = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = !cfg_valid;
                cfg_ready     = 1'b1;
                cmd.accept    = in_valid && !cfg_valid;
                cmd.cfg_write = cfg_valid;
            end
            ST_READ:
            begin
                cmd.load_mem = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready && status.walk_more;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // A result beat is never offered while a new item can be taken.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    // A store read always leads straight to a result beat.
    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EMIT))
        else $error("store read not followed by a result beat");

endmodule : gbn_ctrl
`default_nettype wire

FILE: sv/gbn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_datapath: window state, payload store and result register
// Holds the configuration, the sequence pointers, occupancy and duplicate
// count, the payload ring and the registered result fields.
// ----------------------------------------------------------------------------
module gbn_datapath #(
    parameter int WINDOW_MAX   = gbn_pkg::WINDOW_MAX_DEF,
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gbn_pkg::ctrl_cmd_t                  cmd,
    output gbn_pkg::dp_status_t                      status,
    input  wire logic [gbn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic [1:0]                          func,
    input  wire logic [PAYLOAD_BITS-1:0]             payload,
    input  wire logic [SEQ_BITS-1:0]                 ack_number,
    input  wire logic                                ack_checksum_ok,
    input  wire logic [SEQ_BITS-1:0]                 timeout_seq,
    output logic                                     accepted,
    output logic                                     packet_valid,
    output logic [SEQ_BITS-1:0]                      packet_seq,
    output logic [PAYLOAD_BITS-1:0]                  packet_payload,
    output logic [1:0]                               timer_action,
    output logic [SEQ_BITS-1:0]                      timer_seq,
    output logic                                     window_full,
    output logic                                     last
);
    import gbn_pkg::*;

    localparam int ADDR_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int OCC_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int MOD_BITS  = SEQ_BITS + 1;
    localparam int W_A       = (MOD_BITS > OCC_BITS) ? MOD_BITS : OCC_BITS;
    localparam int W_B       = (W_A > ADDR_BITS + 1) ? W_A : ADDR_BITS + 1;
    localparam int W_C       = (W_B > CFG_MOD_BITS) ? W_B : CFG_MOD_BITS;
    localparam int CALC_BITS = W_C + 1;

    typedef logic [CALC_BITS-1:0] calc_t;

    localparam calc_t MOD_MAX = calc_t'(1) << SEQ_BITS;
    localparam calc_t WIN_MAX = calc_t'(WINDOW_MAX);
    localparam calc_t ONE     = calc_t'(1);
    localparam calc_t TWO     = calc_t'(2);

    // Modular add for operands whose sum stays below twice the modulus.
    function automatic calc_t wrap_add(input calc_t a, input calc_t b, input calc_t md);
        calc_t s;
        s = a + b;
        return (s >= md) ? (s - md) : s;
    endfunction

    // Configuration and window state.
    logic [CFG_LIMIT_BITS-1:0] cfg_lim_reg;
    logic [CFG_MOD_BITS-1:0]   cfg_mod_reg;
    logic [ADDR_BITS-1:0]      head_reg;
    logic [SEQ_BITS-1:0]       base_reg;
    logic [SEQ_BITS-1:0]       nxt_reg;
    logic [OCC_BITS-1:0]       occ_reg;
    logic [1:0]                dup_reg;

    // Resend walk state.
    logic [OCC_BITS-1:0]       walk_idx_reg;
    logic [OCC_BITS-1:0]       walk_cnt_reg;
    logic [ADDR_BITS-1:0]      walk_slot_reg;
    logic [SEQ_BITS-1:0]       walk_seq_reg;
    timer_act_t                first_ta_reg;
    logic [SEQ_BITS-1:0]       first_ts_reg;

    // Result register.
    logic                      acc_reg;
    logic                      pv_reg;
    logic [SEQ_BITS-1:0]       pseq_reg;
    logic [PAYLOAD_BITS-1:0]   ppay_reg;
    timer_act_t                ta_reg;
    logic [SEQ_BITS-1:0]       ts_reg;
    logic                      full_reg;
    logic                      last_reg;

    // Payload store.
    logic [PAYLOAD_BITS-1:0]   mem [WINDOW_MAX];
    logic [PAYLOAD_BITS-1:0]   rd_data_reg;

    // Effective modulus and window limit after clamping.
    calc_t m;
    calc_t lim;
    calc_t mod_raw;
    calc_t lim_raw;

    always_comb
    begin
        mod_raw = calc_t'(cfg_mod_reg);
        lim_raw = calc_t'(cfg_lim_reg);
        if (mod_raw < TWO)
        begin
            m = TWO;
        end
        else if (mod_raw > MOD_MAX)
        begin
            m = MOD_MAX;
        end
        else
        begin
            m = mod_raw;
        end
        lim = (lim_raw < ONE) ? ONE : lim_raw;
        if (lim > WIN_MAX)
        begin
            lim = WIN_MAX;
        end
        if (lim > m - ONE)
        begin
            lim = m - ONE;
        end
    end

    // One step of the window for the item on the input ports.
    calc_t      head_c;
    calc_t      occ_c;
    calc_t      base_c;
    calc_t      nxt_c;
    calc_t      ack_c;
    calc_t      off;
    calc_t      prev;
    calc_t      slot;
    calc_t      head_n;
    calc_t      occ_n;
    calc_t      base_n;
    calc_t      nxt_n;
    logic [1:0] dup_n;
    logic       step_acc;
    logic       step_pv;
    calc_t      step_pseq;
    logic [PAYLOAD_BITS-1:0] step_pay;
    timer_act_t step_ta;
    calc_t      step_ts;
    logic       need_read;
    logic       mem_we;
    calc_t      walk_cnt_n;
    timer_act_t first_ta_n;
    calc_t      first_ts_n;
    logic       full_n;

    always_comb
    begin
        head_c     = calc_t'(head_reg);
        occ_c      = calc_t'(occ_reg);
        base_c     = calc_t'(base_reg);
        nxt_c      = calc_t'(nxt_reg);
        ack_c      = calc_t'(ack_number);
        off        = (ack_c >= base_c) ? (ack_c - base_c) : (ack_c + m - base_c);
        prev       = (base_c == '0) ? (m - ONE) : (base_c - ONE);
        slot       = wrap_add(head_c, occ_c, WIN_MAX);
        head_n     = head_c;
        occ_n      = occ_c;
        base_n     = base_c;
        nxt_n      = nxt_c;
        dup_n      = dup_reg;
        step_acc   = 1'b0;
        step_pv    = 1'b0;
        step_pseq  = '0;
        step_pay   = '0;
        step_ta    = TA_NONE;
        step_ts    = '0;
        need_read  = 1'b0;
        mem_we     = 1'b0;
        walk_cnt_n = ONE;
        first_ta_n = TA_NONE;
        first_ts_n = '0;
        unique case (func_t'(func))
            FUNC_SEND:
            begin
                if (occ_c < lim)
                begin
                    mem_we    = 1'b1;
                    step_acc  = 1'b1;
                    step_pv   = 1'b1;
                    step_pseq = nxt_c;
                    step_pay  = payload;
                    if (occ_c == '0)
                    begin
                        step_ta = TA_START;
                        step_ts = base_c;
                    end
                    nxt_n = wrap_add(nxt_c, ONE, m);
                    occ_n = occ_c + ONE;
                end
            end
            FUNC_ACK:
            begin
                if (ack_checksum_ok && (ack_c < m))
                begin
                    if (off < occ_c)
                    begin
                        // New acknowledgement: slide the base past it.
                        head_n   = wrap_add(head_c, off + ONE, WIN_MAX);
                        occ_n    = occ_c - (off + ONE);
                        base_n   = wrap_add(ack_c, ONE, m);
                        dup_n    = '0;
                        step_acc = 1'b1;
                        if (occ_n != '0)
                        begin
                            step_ta = TA_RESTART;
                            step_ts = base_n;
                        end
                        else
                        begin
                            step_ta = TA_STOP;
                        end
                    end
                    else if ((ack_c == prev) && (dup_reg < DUP_RESEND))
                    begin
                        // Duplicate: the third one resends the oldest packet.
                        if (((dup_reg + 2'd1) == DUP_RESEND) && (occ_c != '0))
                        begin
                            need_read = 1'b1;
                            dup_n     = '0;
                        end
                        else
                        begin
                            dup_n = dup_reg + 2'd1;
                        end
                    end
                end
            end
            FUNC_TIMEOUT:
            begin
                if (occ_c == '0)
                begin
                    step_ta = TA_RESTART;
                    step_ts = calc_t'(timeout_seq);
                end
                else
                begin
                    need_read  = 1'b1;
                    walk_cnt_n = occ_c;
                    first_ta_n = TA_RESTART;
                    first_ts_n = calc_t'(timeout_seq);
                end
            end
            FUNC_NONE:
            begin
                step_acc = 1'b0;
            end
        endcase
        full_n = (occ_n >= lim);
    end

    // Store read address: oldest entry on a new walk, next slot on advance.
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    calc_t                walk_slot_inc;
    calc_t                walk_seq_inc;

    always_comb
    begin
        walk_slot_inc = wrap_add(calc_t'(walk_slot_reg), ONE, WIN_MAX);
        walk_seq_inc  = wrap_add(calc_t'(walk_seq_reg), ONE, m);
        rd_en         = (cmd.accept && need_read) || cmd.advance;
        rd_addr       = cmd.accept ? head_reg : walk_slot_inc[ADDR_BITS-1:0];
    end

    // Payload store write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && mem_we)
        begin
            mem[slot[ADDR_BITS-1:0]] <= payload;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Configuration and window state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_lim_reg <= WINDOW_LIMIT_RESET;
            cfg_mod_reg <= SEQ_MODULUS_RESET;
            head_reg    <= '0;
            base_reg    <= '0;
            nxt_reg     <= '0;
            occ_reg     <= '0;
            dup_reg     <= '0;
        end
        else if (cmd.cfg_write &&
                 ((cfg_index == REG_WINDOW_LIMIT) || (cfg_index == REG_SEQ_MODULUS)))
        begin
            // Any register write flushes the window.
            if (cfg_index == REG_WINDOW_LIMIT)
            begin
                cfg_lim_reg <= cfg_data[CFG_LIMIT_BITS-1:0];
            end
            else
            begin
                cfg_mod_reg <= cfg_data[CFG_MOD_BITS-1:0];
            end
            head_reg <= '0;
            base_reg <= '0;
            nxt_reg  <= '0;
            occ_reg  <= '0;
            dup_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg <= head_n[ADDR_BITS-1:0];
            base_reg <= base_n[SEQ_BITS-1:0];
            nxt_reg  <= nxt_n[SEQ_BITS-1:0];
            occ_reg  <= occ_n[OCC_BITS-1:0];
            dup_reg  <= dup_n;
        end
    end

    // Resend walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && need_read)
        begin
            walk_idx_reg  <= '0;
            walk_cnt_reg  <= walk_cnt_n[OCC_BITS-1:0];
            walk_slot_reg <= head_reg;
            walk_seq_reg  <= base_reg;
            first_ta_reg  <= first_ta_n;
            first_ts_reg  <= first_ts_n[SEQ_BITS-1:0];
        end
        else if (cmd.advance)
        begin
            walk_idx_reg  <= walk_idx_reg + OCC_BITS'(1);
            walk_slot_reg <= walk_slot_inc[ADDR_BITS-1:0];
            walk_seq_reg  <= walk_seq_inc[SEQ_BITS-1:0];
        end
    end

    // Result payload fields.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !need_read)
        begin
            acc_reg  <= step_acc;
            pv_reg   <= step_pv;
            pseq_reg <= step_pseq[SEQ_BITS-1:0];
            ppay_reg <= step_pay;
            ta_reg   <= step_ta;
            ts_reg   <= step_ts[SEQ_BITS-1:0];
            full_reg <= full_n;
        end
        else if (cmd.load_mem)
        begin
            acc_reg  <= 1'b0;
            pv_reg   <= 1'b1;
            pseq_reg <= walk_seq_reg;
            ppay_reg <= rd_data_reg;
            ta_reg   <= (walk_idx_reg == '0) ? first_ta_reg : TA_NONE;
            ts_reg   <= (walk_idx_reg == '0) ? first_ts_reg : '0;
            full_reg <= (calc_t'(occ_reg) >= lim);
        end
    end

    // End-of-item mark, also telling the controller whether a walk goes on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b1;
        end
        else if (cmd.accept && !need_read)
        begin
            last_reg <= 1'b1;
        end
        else if (cmd.load_mem)
        begin
            last_reg <= ((walk_idx_reg + OCC_BITS'(1)) == walk_cnt_reg);
        end
    end

    assign status.need_read = need_read;
    assign status.walk_more = !last_reg;

    assign accepted       = acc_reg;
    assign packet_valid   = pv_reg;
    assign packet_seq     = pseq_reg;
    assign packet_payload = ppay_reg;
    assign timer_action   = ta_reg;
    assign timer_seq      = ts_reg;
    assign window_full    = full_reg;
    assign last           = last_reg;

    // Occupancy never exceeds the effective window limit.
    a_occ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        calc_t'(occ_reg) <= lim)
        else $error("window occupancy above limit");

    // Sequence pointers stay inside the sequence space.
    a_seq_in_space: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_t'(base_reg) < m) && (calc_t'(nxt_reg) < m))
        else $error("sequence pointer outside sequence space");

    // A walk never loads more packets than it was started with.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_mem |-> (walk_idx_reg < walk_cnt_reg))
        else $error("resend walk overran its count");

endmodule : gbn_datapath
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the go-back-N sender window
// Drives send, ACK, timer-expiry and idle-code events into the block and
// mirrors the window in a tracker class that predicts every result beat.
// Each result beat is compared field by field with the oldest prediction.
// The window settings are changed between phases, and sender gaps and
// receiver stalls are varied, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import gbn_pkg::*;

    localparam int WMAX         = WINDOW_MAX_DEF;
    localparam int SEQ_W        = SEQ_BITS_DEF;
    localparam int PAY_W        = PAYLOAD_BITS_DEF;
    localparam int HEAD_W       = $clog2(WMAX);
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASES       = 7;
    localparam int PHASE_EVENTS = 20;
    localparam int HOLD_CYCLES  = 80;
    localparam int PEND_DEPTH   = 64;

    // One event offered on the input channel.
    typedef struct {
        func_t             func;
        logic [PAY_W-1:0]  payload;
        logic [SEQ_W-1:0]  ack_number;
        logic              ack_ok;
        logic [SEQ_W-1:0]  timeout_seq;
    } net_event_t;

    // One result beat of the output channel.
    typedef struct {
        logic              accepted;
        logic              packet_valid;
        logic [SEQ_W-1:0]  packet_seq;
        logic [PAY_W-1:0]  packet_payload;
        logic [1:0]        timer_action;
        logic [SEQ_W-1:0]  timer_seq;
        logic              window_full;
        logic              last;
    } beat_t;

    // Shadow of the sender window: predicts the result beats of each
    // accepted event and checks the beats that the block delivers.
    class window_tracker;
        logic [PAY_W-1:0]         words [WMAX];
        bit [HEAD_W-1:0]          head;
        bit [SEQ_W-1:0]           base_seq;
        bit [SEQ_W-1:0]           next_seq;
        bit [HEAD_W:0]            occupancy;
        bit [1:0]                 dup_count;
        bit [CFG_LIMIT_BITS-1:0]  limit_reg;
        bit [CFG_MOD_BITS-1:0]    modulus_reg;
        beat_t                    pending_beats [PEND_DEPTH];
        int unsigned              pend_wr;
        int unsigned              pend_rd;
        int unsigned              mismatches;
        int unsigned              beats_checked;
        int unsigned              fast_resends;
        int unsigned              timeout_walks;
        int unsigned              events_by_func [4];

        function void flush();
            head      = '0;
            base_seq  = '0;
            next_seq  = '0;
            occupancy = '0;
            dup_count = '0;
        endfunction

        function void clear_all();
            limit_reg   = WINDOW_LIMIT_RESET;
            modulus_reg = SEQ_MODULUS_RESET;
            flush();
        endfunction

        // Beats predicted but not yet seen.
        function int unsigned pending_count();
            return pend_wr - pend_rd;
        endfunction

        function void store_beat(beat_t b);
            pending_beats[pend_wr % PEND_DEPTH] = b;
            pend_wr++;
        endfunction

        // Sequence space actually in use.
        function int unsigned modulus();
            int unsigned m;
            m = modulus_reg;
            if (m < 2)
                m = 2;
            if (m > (1 << SEQ_W))
                m = 1 << SEQ_W;
            return m;
        endfunction

        // Window limit actually in use: clamped to the store and the space.
        function int unsigned limit();
            int unsigned l;
            int unsigned m;
            l = limit_reg;
            m = modulus();
            if (l < 1)
                l = 1;
            if (l > WMAX)
                l = WMAX;
            if (l > m - 1)
                l = m - 1;
            return l;
        endfunction

        // Any register write flushes the window; stored words survive.
        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_WINDOW_LIMIT)
            begin
                limit_reg = data[CFG_LIMIT_BITS-1:0];
                flush();
            end
            else if (idx == REG_SEQ_MODULUS)
            begin
                modulus_reg = data;
                flush();
            end
        endfunction

        function void take_event(net_event_t ev);
            beat_t        b;
            beat_t        burst [WMAX];
            int unsigned  n_burst;
            int unsigned  m;
            int unsigned  lim;
            int unsigned  off;
            int unsigned  prev;
            m       = modulus();
            lim     = limit();
            n_burst = 0;
            b       = '{default: '0};
            events_by_func[ev.func]++;
            case (ev.func)
                FUNC_SEND:
                begin
                    // A full window refuses the send outright.
                    if (occupancy < lim)
                    begin
                        words[(head + occupancy) % WMAX] = ev.payload;
                        b.accepted       = 1'b1;
                        b.packet_valid   = 1'b1;
                        b.packet_seq     = next_seq;
                        b.packet_payload = ev.payload;
                        if (occupancy == 0)
                        begin
                            b.timer_action = TA_START;
                            b.timer_seq    = base_seq;
                        end
                        next_seq  = SEQ_W'((next_seq + 1) % m);
                        occupancy = occupancy + 1'b1;
                    end
                    burst[n_burst] = b;
                    n_burst++;
                end
                FUNC_ACK:
                begin
                    if (ev.ack_ok && ev.ack_number < m)
                    begin
                        off  = (ev.ack_number + m - base_seq) % m;
                        prev = (base_seq + m - 1) % m;
                        if (off < occupancy)
                        begin
                            // Cumulative ACK: slide the base past it.
                            head      = HEAD_W'((head + off + 1) % WMAX);
                            occupancy = occupancy - (HEAD_W + 1)'(off + 1);
                            base_seq  = SEQ_W'((ev.ack_number + 1) % m);
                            dup_count = '0;
                            b.accepted = 1'b1;
                            if (occupancy != 0)
                            begin
                                b.timer_action = TA_RESTART;
                                b.timer_seq    = base_seq;
                            end
                            else
                                b.timer_action = TA_STOP;
                        end
                        else if (ev.ack_number == prev && dup_count < DUP_RESEND)
                        begin
                            // The third duplicate resends the oldest packet;
                            // with an empty window the count sticks.
                            dup_count = dup_count + 1'b1;
                            if (dup_count == DUP_RESEND && occupancy != 0)
                            begin
                                b.packet_valid   = 1'b1;
                                b.packet_seq     = base_seq;
                                b.packet_payload = words[head];
                                dup_count        = '0;
                                fast_resends++;
                            end
                        end
                    end
                    burst[n_burst] = b;
                    n_burst++;
                end
                FUNC_TIMEOUT:
                begin
                    if (occupancy == 0)
                    begin
                        b.timer_action = TA_RESTART;
                        b.timer_seq    = ev.timeout_seq;
                        burst[n_burst] = b;
                        n_burst++;
                    end
                    else
                    begin
                        // Go back N: resend the whole window in order.
                        timeout_walks++;
                        for (int i = 0; i < occupancy; i++)
                        begin
                            b = '{default: '0};
                            b.packet_valid   = 1'b1;
                            b.packet_seq     = SEQ_W'((base_seq + i) % m);
                            b.packet_payload = words[(head + i) % WMAX];
                            if (i == 0)
                            begin
                                b.timer_action = TA_RESTART;
                                b.timer_seq    = ev.timeout_seq;
                            end
                            burst[n_burst] = b;
                            n_burst++;
                        end
                    end
                end
                default:
                begin
                    burst[n_burst] = b;
                    n_burst++;
                end
            endcase

            // Occupancy after the event is flagged on every beat.
            for (int k = 0; k < n_burst; k++)
            begin
                burst[k].window_full = (occupancy >= lim);
                burst[k].last        = (k == n_burst - 1);
                store_beat(burst[k]);
            end
        endfunction

        function void compare(string field, logic [PAY_W-1:0] want,
                              logic [PAY_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (pending_count() == 0)
            begin
                $error("result beat arrived with nothing outstanding");
                mismatches++;
                return;
            end
            want = pending_beats[pend_rd % PEND_DEPTH];
            pend_rd++;
            beats_checked++;
            compare("accepted", want.accepted, got.accepted);
            compare("packet_valid", want.packet_valid, got.packet_valid);
            compare("packet_seq", want.packet_seq, got.packet_seq);
            compare("packet_payload", want.packet_payload, got.packet_payload);
            compare("timer_action", want.timer_action, got.timer_action);
            compare("timer_seq", want.timer_seq, got.timer_seq);
            compare("window_full", want.window_full, got.window_full);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 func;
    logic [PAY_W-1:0]           payload;
    logic [SEQ_W-1:0]           ack_number;
    logic                       ack_checksum_ok;
    logic [SEQ_W-1:0]           timeout_seq;
    logic                       out_valid;
    logic                       out_ready;
    logic                       accepted;
    logic                       packet_valid;
    logic [SEQ_W-1:0]           packet_seq;
    logic [PAY_W-1:0]           packet_payload;
    logic [1:0]                 timer_action;
    logic [SEQ_W-1:0]           timer_seq;
    logic                       window_full;
    logic                       last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    window_tracker  tracker = new;
    beat_t          seen_beat;
    int unsigned    sender_idle_pct = 0;
    int unsigned    recv_stall_pct  = 0;
    int unsigned    hold_left       = 0;
    int unsigned    quiet_cycles    = 0;
    int unsigned    dup_left        = 0;

    go_back_n_sender_window i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .payload         (payload),
        .ack_number      (ack_number),
        .ack_checksum_ok (ack_checksum_ok),
        .timeout_seq     (timeout_seq),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .accepted        (accepted),
        .packet_valid    (packet_valid),
        .packet_seq      (packet_seq),
        .packet_payload  (packet_payload),
        .timer_action    (timer_action),
        .timer_seq       (timer_seq),
        .window_full     (window_full),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock: period 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: a pending hold-off wins, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every result beat that is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_beat = '{accepted, packet_valid, packet_seq, packet_payload,
                          timer_action, timer_seq, window_full, last};
            tracker.check_beat(seen_beat);
        end
    end

    // Watchdog: ends the run after too long without any beat moving.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles < QUIET_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("go_back_n_sender_window: mismatch");
            $finish;
        end
    end

    function automatic net_event_t make_event(func_t f, logic [PAY_W-1:0] pay,
                                              logic [SEQ_W-1:0] ack, logic ok,
                                              logic [SEQ_W-1:0] tseq);
        net_event_t ev;
        ev.func        = f;
        ev.payload     = pay;
        ev.ack_number  = ack;
        ev.ack_ok      = ok;
        ev.timeout_seq = tseq;
        return ev;
    endfunction

    // Mostly well-formed traffic that follows the current window, with
    // bursts of three duplicates and a share of noise.
    function automatic net_event_t next_random_event();
        net_event_t   ev;
        int unsigned  m;
        int unsigned  occ;
        int unsigned  base;
        int unsigned  r;
        m    = tracker.modulus();
        occ  = tracker.occupancy;
        base = tracker.base_seq;
        ev   = make_event(FUNC_SEND, $urandom(), SEQ_W'($urandom()), 1'b1,
                          SEQ_W'($urandom()));
        r    = $urandom_range(99);
        if (dup_left != 0)
        begin
            dup_left--;
            ev.func       = FUNC_ACK;
            ev.ack_number = SEQ_W'((base + m - 1) % m);
        end
        else if (r < 40 || (r < 65 && occ == 0))
        begin
            if ($urandom_range(7) == 0)
                ev.payload = $urandom_range(1) ? '1 : '0;
        end
        else if (r < 65)
        begin
            ev.func       = FUNC_ACK;
            ev.ack_number = SEQ_W'((base + $urandom_range(occ - 1)) % m);
        end
        else if (r < 75)
        begin
            ev.func       = FUNC_ACK;
            ev.ack_number = SEQ_W'((base + m - 1) % m);
            dup_left      = 2;
        end
        else if (r < 85)
            ev.func = FUNC_TIMEOUT;
        else
        begin
            case ($urandom_range(3))
                0: ev.func = FUNC_NONE;
                1:
                begin
                    ev.func   = FUNC_ACK;
                    ev.ack_ok = 1'b0;
                end
                2:
                begin
                    ev.func   = FUNC_ACK;
                    ev.ack_ok = 1'($urandom_range(1));
                end
                default:
                begin
                    ev.func = FUNC_ACK;
                    if (m < (1 << SEQ_W))
                        ev.ack_number = SEQ_W'($urandom_range((1 << SEQ_W) - 1, m));
                end
            endcase
        end
        return ev;
    endfunction

    // Offer one event beat, note it when taken, then maybe leave a gap.
    task automatic put_event(net_event_t ev);
        int unsigned gap;
        func            <= ev.func;
        payload         <= ev.payload;
        ack_number      <= ev.ack_number;
        ack_checksum_ok <= ev.ack_ok;
        timeout_seq     <= ev.timeout_seq;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_event(ev);
        gap = 0;
        while (gap < 16 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted beat has been seen.
    task automatic drain(int unsigned settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                             logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Window settings per phase, with sender idling and receiver stalls.
    // Limit data above 15 checks that only the low four bits count.
    logic [CFG_DATA_BITS-1:0] limit_plan   [PHASES] = '{8, 1, 0, 31, 24, 3, 7};
    logic [CFG_DATA_BITS-1:0] modulus_plan [PHASES] = '{16, 2, 0, 31, 5, 9, 12};
    int unsigned              idle_plan    [PHASES] = '{66, 0, 25, 0, 66, 0, 25};
    int unsigned              stall_plan   [PHASES] = '{0, 66, 25, 0, 0, 66, 25};

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        func            <= FUNC_SEND;
        payload         <= '0;
        ack_number      <= '0;
        ack_checksum_ok <= 1'b0;
        timeout_seq     <= '0;
        out_ready       <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        tracker.clear_all();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under the reset settings: limit 4, modulus 8.
        // Expiry and idle code on an empty window.
        put_event(make_event(FUNC_TIMEOUT, $urandom(), 4'd3, 1'b1, 4'd15));
        put_event(make_event(FUNC_NONE, $urandom(), 4'd9, 1'b0, 4'd6));
        // Duplicates of base-1 with nothing outstanding: the count sticks.
        repeat (4) put_event(make_event(FUNC_ACK, $urandom(), 4'd7, 1'b1, 4'd0));
        // Fill the window, then one send too many.
        put_event(make_event(FUNC_SEND, '0, 4'd0, 1'b0, 4'd0));
        put_event(make_event(FUNC_SEND, '1, 4'd15, 1'b1, 4'd15));
        repeat (3) put_event(make_event(FUNC_SEND, $urandom(), 4'd5, 1'b1, 4'd9));
        // ACK outside the number space, bad checksum, full resend.
        put_event(make_event(FUNC_ACK, $urandom(), 4'd15, 1'b1, 4'd2));
        put_event(make_event(FUNC_ACK, $urandom(), 4'd1, 1'b0, 4'd2));
        put_event(make_event(FUNC_TIMEOUT, $urandom(), 4'd0, 1'b0, 4'd0));
        // ACK neither new nor duplicate, then a new one.
        put_event(make_event(FUNC_ACK, $urandom(), 4'd5, 1'b1, 4'd1));
        put_event(make_event(FUNC_ACK, $urandom(), 4'd0, 1'b1, 4'd1));
        // Three duplicates trigger a fast resend of the oldest packet.
        repeat (3) put_event(make_event(FUNC_ACK, $urandom(), 4'd0, 1'b1, 4'd4));
        // Cumulative ACK that empties the window.
        put_event(make_event(FUNC_ACK, $urandom(), 4'd3, 1'b1, 4'd8));

        // Random phases, each under its own window setting.
        for (int p = 0; p < PHASES; p++)
        begin
            drain(4);
            dup_left = 0;
            sender_idle_pct <= idle_plan[p];
            recv_stall_pct  <= stall_plan[p];
            if (p % 2 != 0)
            begin
                write_reg(REG_SEQ_MODULUS, modulus_plan[p]);
                write_reg(REG_WINDOW_LIMIT, limit_plan[p]);
            end
            else
            begin
                write_reg(REG_WINDOW_LIMIT, limit_plan[p]);
                write_reg(REG_SEQ_MODULUS, modulus_plan[p]);
            end
            // Long receiver hold-off while events keep coming.
            if (p == 3)
                hold_left <= HOLD_CYCLES;
            repeat (PHASE_EVENTS) put_event(next_random_event());
        end

        drain(3 * WMAX + 6);
        $display("Covered %0d sends, %0d ACKs, %0d timer expiries and %0d idle codes",
                 tracker.events_by_func[FUNC_SEND], tracker.events_by_func[FUNC_ACK],
                 tracker.events_by_func[FUNC_TIMEOUT], tracker.events_by_func[FUNC_NONE]);
        $display("over %0d window settings; %0d beats checked, %0d fast resends, %0d walks.",
                 PHASES + 1, tracker.beats_checked, tracker.fast_resends,
                 tracker.timeout_walks);
        if (tracker.mismatches == 0)
            $display("go_back_n_sender_window: match");
        else
            $display("go_back_n_sender_window: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
sv/gbn_pkg.sv
sv/gbn_ctrl.sv
sv/gbn_datapath.sv
sv/go_back_n_sender_window.sv
tb/tb_top.sv
